// File: rtl/core/iglcu_pkg.sv
package iglcu_pkg;

  localparam int OpW = 32;
  localparam int ResW = 64;

  typedef enum logic [2:0] {
    FN_GCD  = 3'd0,
    FN_LCM  = 3'd1,
    FN_FACT = 3'd2,
    FN_NPR  = 3'd3,
    FN_NCR  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]     func;
    logic [OpW-1:0] operand_a;
    logic [OpW-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [ResW-1:0] result;
    logic [1:0]      status;
  } rsp_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,      // latch request, x=a y=b
    DP_DIV_XY,    // start divide x / y
    DP_EUCLID,    // x=y, y=remainder
    DP_LCM_Q,     // start divide a / x(gcd)
    DP_LCM_MUL,   // start mul quotient * b
    DP_PROD_INIT, // p=1, i=1, setup lo, k
    DP_PROD_MUL,  // start mul p*(lo+i) or for ncr p*((n-k+i)/d)
    DP_PROD_ACC,  // p=prod, i++
    DP_NCR_GCD,   // x=c, y=i
    DP_NCR_D,     // start divide i / g
    DP_NCR_C,     // save d, start divide c / g
    DP_NCR_X,     // save c, start divide (n-k+i) / d
    DP_FINISH     // capture output
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;   // divider or multiplier finished
    logic y_zero;
    logic ab_zero;     // a or b zero
    logic b_gt_a;
    logic loop_done;   // i > k
    logic ovf;         // last product overflowed
  } dp_stat_t;

endpackage

// File: rtl/core/iglcu_ctrl.sv
module iglcu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           func,
  input  iglcu_pkg::dp_stat_t  stat,
  output iglcu_pkg::dp_cmd_t   cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DISP   = 12'b000000000010,
    S_GDIV   = 12'b000000000100,
    S_GWAIT  = 12'b000000001000,
    S_LQW    = 12'b000000010000,
    S_LMW    = 12'b000000100000,
    S_PTEST  = 12'b000001000000,
    S_PWAIT  = 12'b000010000000,
    S_NGCD   = 12'b000100000000,
    S_NDIV   = 12'b001000000000,
    S_FIN    = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic [2:0] fn, fn_next;
  logic [1:0] ncr_ph, ncr_ph_next;   // 0 d, 1 c, 2 x
  iglcu_pkg::status_t st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fn     <= 3'd0;
      ncr_ph <= 2'd0;
      st     <= iglcu_pkg::ST_OK;
    end else begin
      state  <= state_next;
      fn     <= fn_next;
      ncr_ph <= ncr_ph_next;
      st     <= st_next;
    end
  end

  always_comb begin
    state_next  = state;
    fn_next     = fn;
    ncr_ph_next = ncr_ph;
    st_next     = st;
    cmd.op      = iglcu_pkg::DP_NOP;
    cmd.st      = st;
    done        = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = iglcu_pkg::DP_LOAD;
          fn_next    = func;
          st_next    = iglcu_pkg::ST_OK;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (fn)
          iglcu_pkg::FN_GCD: state_next = S_GDIV;
          iglcu_pkg::FN_LCM: begin
            if (stat.ab_zero) state_next = S_FIN;
            else state_next = S_GDIV;
          end
          iglcu_pkg::FN_FACT: begin
            cmd.op = iglcu_pkg::DP_PROD_INIT;
            state_next = S_PTEST;
          end
          iglcu_pkg::FN_NPR, iglcu_pkg::FN_NCR: begin
            if (stat.b_gt_a) begin
              st_next = iglcu_pkg::ST_INVALID;
              state_next = S_FIN;
            end else begin
              cmd.op = iglcu_pkg::DP_PROD_INIT;
              state_next = S_PTEST;
            end
          end
          default: begin
            st_next = iglcu_pkg::ST_INVALID;
            state_next = S_FIN;
          end
        endcase
      end
      S_GDIV: begin
        if (stat.y_zero) begin
          if (fn == iglcu_pkg::FN_LCM) begin
            cmd.op = iglcu_pkg::DP_LCM_Q;
            state_next = S_LQW;
          end else if (fn == iglcu_pkg::FN_NCR) begin
            cmd.op = iglcu_pkg::DP_NCR_D;
            ncr_ph_next = 2'd0;
            state_next = S_NDIV;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          cmd.op = iglcu_pkg::DP_DIV_XY;
          state_next = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (stat.unit_done) begin
          cmd.op = iglcu_pkg::DP_EUCLID;
          state_next = S_GDIV;
        end
      end
      S_LQW: begin
        if (stat.unit_done) begin
          cmd.op = iglcu_pkg::DP_LCM_MUL;
          state_next = S_LMW;
        end
      end
      S_LMW: begin
        if (stat.unit_done) begin
          cmd.op = iglcu_pkg::DP_PROD_ACC;
          state_next = S_FIN;
        end
      end
      S_PTEST: begin
        if (stat.loop_done) begin
          state_next = S_FIN;
        end else if (fn == iglcu_pkg::FN_NCR) begin
          cmd.op = iglcu_pkg::DP_NCR_GCD;
          state_next = S_GDIV;
        end else begin
          cmd.op = iglcu_pkg::DP_PROD_MUL;
          state_next = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (stat.unit_done) begin
          if (stat.ovf) begin
            st_next = iglcu_pkg::ST_OVERFLOW;
            state_next = S_FIN;
          end else begin
            cmd.op = iglcu_pkg::DP_PROD_ACC;
            state_next = S_PTEST;
          end
        end
      end
      S_NDIV: begin
        if (stat.unit_done) begin
          if (ncr_ph == 2'd0) begin
            cmd.op = iglcu_pkg::DP_NCR_C;
            ncr_ph_next = 2'd1;
          end else if (ncr_ph == 2'd1) begin
            cmd.op = iglcu_pkg::DP_NCR_X;
            ncr_ph_next = 2'd2;
          end else begin
            cmd.op = iglcu_pkg::DP_PROD_MUL;
            state_next = S_PWAIT;
          end
        end
      end
      S_NGCD: state_next = S_GDIV;
      S_FIN: begin
        cmd.op = iglcu_pkg::DP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/core/iglcu_div.sv
// radix-2 restoring divider, 64-bit, one quotient bit per cycle
module iglcu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);

  logic [6:0]  cnt;
  logic        run;
  logic [63:0] q, r, d;
  logic [64:0] trial;

  assign trial = {r[63:0], q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= 7'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 7'd0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q <= dividend;
      r <= 64'd0;
      d <= divisor;
    end else if (run) begin
      if (!trial[64]) begin
        r <= trial[63:0];
        q <= {q[62:0], 1'b1};
      end else begin
        r <= {r[62:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

// File: rtl/core/iglcu_mul.sv
// 64x64 multiply from four 32x32 partial products, one per cycle,
// flags any product bits above 64
module iglcu_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic        done,
  output logic [63:0] prod,
  output logic        ovf
);

  logic [2:0]  step;
  logic        run;
  logic [63:0] xr, yr, pp;
  logic [31:0] ma, mb;
  logic [129:0] acc;

  always_comb begin
    case (step)
      3'd0: begin ma = xr[31:0];  mb = yr[31:0];  end
      3'd1: begin ma = xr[63:32]; mb = yr[31:0];  end
      3'd2: begin ma = xr[31:0];  mb = yr[63:32]; end
      default: begin ma = xr[63:32]; mb = yr[63:32]; end
    endcase
  end

  always_ff @(posedge clk) begin
    pp <= {32'd0, ma} * {32'd0, mb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        step <= 3'd0;
      end else if (run) begin
        step <= step + 3'd1;
        if (step == 3'd4) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // pp holds the product selected in the cycle before
  always_ff @(posedge clk) begin
    if (go) begin
      xr  <= x;
      yr  <= y;
      acc <= 130'd0;
    end else if (run) begin
      case (step)
        3'd1: acc <= acc + {66'd0, pp};
        3'd2, 3'd3: acc <= acc + {34'd0, pp, 32'd0};
        3'd4: acc <= acc + {2'd0, pp, 64'd0};
        default: acc <= acc;
      endcase
    end
  end

  assign prod = acc[63:0];
  assign ovf  = |acc[129:64];

endmodule

// File: rtl/core/iglcu_dp.sv
module iglcu_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  iglcu_pkg::req_t      req,
  input  iglcu_pkg::dp_cmd_t   cmd,
  output iglcu_pkg::dp_stat_t  stat,
  output iglcu_pkg::rsp_t      rsp
);

  logic [63:0] a, b, x, y, p, i, k, lo, dv;
  logic        div_go, mul_go, div_done, mul_done, mul_ovf;
  logic [63:0] div_n, div_d, div_q, div_r, mul_x, mul_y, mul_p;
  logic [63:0] nmk;

  assign nmk = a - b;

  iglcu_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  iglcu_mul u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .x(mul_x), .y(mul_y),
    .done(mul_done), .prod(mul_p), .ovf(mul_ovf)
  );

  always_comb begin
    div_go = 1'b0;
    div_n  = x;
    div_d  = y;
    mul_go = 1'b0;
    mul_x  = p;
    mul_y  = lo + i;
    case (cmd.op)
      iglcu_pkg::DP_DIV_XY: div_go = 1'b1;
      iglcu_pkg::DP_LCM_Q: begin
        div_go = 1'b1; div_n = a; div_d = x;
      end
      iglcu_pkg::DP_LCM_MUL: begin
        mul_go = 1'b1; mul_x = div_q; mul_y = b;
      end
      iglcu_pkg::DP_NCR_D: begin
        div_go = 1'b1; div_n = i; div_d = x;
      end
      iglcu_pkg::DP_NCR_C: begin
        div_go = 1'b1; div_n = p; div_d = x;
      end
      iglcu_pkg::DP_NCR_X: begin
        div_go = 1'b1; div_n = lo + i; div_d = dv;
      end
      iglcu_pkg::DP_PROD_MUL: begin
        mul_go = 1'b1;
        if (req.func == iglcu_pkg::FN_NCR) mul_y = div_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      iglcu_pkg::DP_LOAD: begin
        a <= {{(64-iglcu_pkg::OpW){1'b0}}, req.operand_a};
        b <= {{(64-iglcu_pkg::OpW){1'b0}}, req.operand_b};
        x <= {{(64-iglcu_pkg::OpW){1'b0}}, req.operand_a};
        y <= {{(64-iglcu_pkg::OpW){1'b0}}, req.operand_b};
        p <= 64'd0;
      end
      iglcu_pkg::DP_EUCLID: begin
        x <= y; y <= div_r;
      end
      iglcu_pkg::DP_PROD_INIT: begin
        p <= 64'd1;
        i <= 64'd1;
        if (req.func == iglcu_pkg::FN_FACT) begin
          lo <= 64'd0; k <= a;
        end else if (req.func == iglcu_pkg::FN_NPR) begin
          lo <= nmk; k <= b;
        end else if (b > nmk) begin
          lo <= b; k <= nmk;
        end else begin
          lo <= nmk; k <= b;
        end
      end
      iglcu_pkg::DP_NCR_GCD: begin
        x <= p; y <= i;
      end
      iglcu_pkg::DP_NCR_C: dv <= div_q;
      iglcu_pkg::DP_NCR_X: p <= div_q;
      iglcu_pkg::DP_PROD_ACC: begin
        p <= mul_p; i <= i + 64'd1;
      end
      iglcu_pkg::DP_FINISH: begin
        rsp.status <= cmd.st;
        if (cmd.st != iglcu_pkg::ST_OK) rsp.result <= 64'd0;
        else if (req.func == iglcu_pkg::FN_GCD) rsp.result <= x;
        else rsp.result <= p;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.unit_done = div_done | mul_done;
    stat.y_zero    = (y == 64'd0);
    stat.ab_zero   = (a == 64'd0) || (b == 64'd0);
    stat.b_gt_a    = (b > a);
    stat.loop_done = (i > k);
    stat.ovf       = mul_ovf;
  end

endmodule

// File: rtl/core/integer_gcd_lcm_combinatorics_unit.sv
// Integer GCD / LCM / factorial / nPr / nCr unit.
// Request channel: drive req (func, operand_a, operand_b) and pulse start;
// the word is taken at a clock edge with start high and busy low. The
// request is held inside, so req may change after that edge.
// Response channel: done is high for exactly one cycle and rsp (result,
// status) is valid in that cycle. The receiver cannot stall; it must take
// the word then. Status is ok, invalid (r above n, or an unused code) or
// overflow (true value above 64 bits); result is zero when not ok.
// GCD runs Euclid steps, each a radix-2 division plus issue and handoff;
// LCM adds one division and a multiply. Factorial and nPr take one
// multiply per factor; nCr takes, per factor, gcd steps, three divisions
// and a multiply. Overflow stops a product loop at once. An invalid word
// goes straight to the finish state. One request at a time; busy stays
// high throughout. All divisions share the one divider.
// Reset (rst, synchronous) returns the controller to idle and drops any
// request in flight; no response follows for it.
module integer_gcd_lcm_combinatorics_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  iglcu_pkg::req_t  req,
  output logic             busy,
  output logic             done,
  output iglcu_pkg::rsp_t  rsp
);

  iglcu_pkg::dp_cmd_t  cmd;
  iglcu_pkg::dp_stat_t stat;
  iglcu_pkg::req_t     req_q;

  // request register, loaded at acceptance
  always_ff @(posedge clk) begin
    if (start && !busy) req_q <= req;
  end

  iglcu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(req.func),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done)
  );

  iglcu_dp u_dp (
    .clk(clk), .rst(rst), .req((start && !busy) ? req : req_q),
    .cmd(cmd), .stat(stat), .rsp(rsp)
  );

endmodule

// File: rtl/core/iglcu_checker.sv
module iglcu_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input iglcu_pkg::rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
  a_zero_bad: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != iglcu_pkg::ST_OK) |-> rsp.result == 64'd0)
    else $error("nonzero result on error");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status != 2'd3) else $error("bad status");

endmodule

bind integer_gcd_lcm_combinatorics_unit iglcu_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
